// ===== rtl/core/hpf_pkg.sv =====
// Shared types and constants for the harmonic pair force pipeline.
// No dependencies; imported by every module of the block.
package hpf_pkg;

	localparam int ROOT_W = 32;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int QUO_W  = 49;
	localparam int NUM_W  = 81;
	localparam int LANES  = 3;

	localparam logic [47:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] FORCE_NEG_MIN = 48'h8000_0000_0000;
	localparam logic [48:0] FORCE_NEG_MAG = 49'h0_8000_0000_0000;
	localparam logic [48:0] FORCE_POS_MAG = 49'h0_7FFF_FFFF_FFFF;
	localparam logic [46:0] ENERGY_MAX    = 47'h7FFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		REG_K_AA  = 3'd0,
		REG_K_AB  = 3'd1,
		REG_K_BB  = 3'd2,
		REG_R0_AA = 3'd3,
		REG_R0_AB = 3'd4,
		REG_R0_BB = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		PAIR_AA = 2'd0,
		PAIR_AB = 2'd1,
		PAIR_BB = 2'd2
	} pair_t;

	typedef struct packed {
		logic [LANES-1:0][31:0] mag;
		logic [LANES-1:0]       neg;
		pair_t                  pair;
		logic [16:0]            weight;
	} sq_side_t;

	typedef struct packed {
		logic [ROOT_W-1:0] den;
		logic [LANES-1:0]  fneg;
		logic [LANES-1:0]  live;
		logic [46:0]       energy;
		logic              eclip;
	} dv_side_t;

endpackage

// ===== rtl/core/hpf_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on hpf_pkg; carries the item's side data alongside.
module hpf_sqrt import hpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  rad,
	input  sq_side_t          in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root,
	output sq_side_t          out_side
);

	logic              vld_s  [ROOT_W+1];
	logic [RAD_W-1:0]  rad_s  [ROOT_W+1];
	logic [ROOT_W+1:0] rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0] root_s [ROOT_W+1];
	sq_side_t          side_s [ROOT_W+1];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [ROOT_W+3:0] cat;
		logic [ROOT_W+1:0] trial;
		logic              take;

		assign cat   = {rem_s[i], rad_s[i][RAD_W-1 -: 2]};
		assign trial = {root_s[i], 2'b01};
		assign take  = cat >= {2'b00, trial};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= {rad_s[i][RAD_W-3:0], 2'b00};
				rem_s[i+1]  <= take ? (ROOT_W+2)'(cat - {2'b00, trial}) : (ROOT_W+2)'(cat);
				root_s[i+1] <= {root_s[i][ROOT_W-2:0], take};
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W];
	assign root     = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];

	// The final remainder of a floor square root never exceeds twice the root.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> rem_s[ROOT_W] <= {1'b0, root_s[ROOT_W], 1'b0})
		else $error("sqrt remainder exceeds twice the root");

endmodule

// ===== rtl/core/hpf_div.sv =====
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on hpf_pkg; carries the item's side data alongside.
module hpf_div import hpf_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  dv_side_t                    in_side,
	output logic                        out_vld,
	output logic [LANES-1:0][QUO_W-1:0] quo,
	output dv_side_t                    out_side
);

	localparam int REM_W = NUM_W - QUO_W;

	logic                        vld_s  [QUO_W+1];
	logic [LANES-1:0][REM_W-1:0] rem_s  [QUO_W+1];
	logic [LANES-1:0][QUO_W-1:0] lq_s   [QUO_W+1];
	dv_side_t                    side_s [QUO_W+1];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem_s[0][l] = num[l][NUM_W-1 -: REM_W];
			lq_s[0][l]  = num[l][QUO_W-1:0];
		end
	end

	assign vld_s[0]  = in_vld;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < QUO_W; i++) begin : g_stage
		logic [LANES-1:0][REM_W:0] cat;
		logic [LANES-1:0]          take;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				cat[l]  = {rem_s[i][l], lq_s[i][l][QUO_W-1]};
				take[l] = cat[l] >= {1'b0, side_s[i].den};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[i+1][l] <= take[l] ? REM_W'(cat[l] - {1'b0, side_s[i].den})
						: REM_W'(cat[l]);
					lq_s[i+1][l]  <= {lq_s[i][l][QUO_W-2:0], take[l]};
				end
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_vld  = vld_s[QUO_W];
	assign quo      = lq_s[QUO_W];
	assign out_side = side_s[QUO_W];

	// Every live lane ends with a remainder below the divisor.
	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld |-> (!out_side.live[0] || rem_s[QUO_W][0] < out_side.den)
			&& (!out_side.live[1] || rem_s[QUO_W][1] < out_side.den)
			&& (!out_side.live[2] || rem_s[QUO_W][2] < out_side.den))
		else $error("divider remainder not below divisor");

endmodule

// ===== rtl/core/harmonic_pair_force_unit.sv =====
// Harmonic pair force top: config registers, multiply stages, square root, divider, output register.
// Depends on hpf_pkg, hpf_sqrt and hpf_div.
//
//   Channel  Signals                                          Direction
//   in       in_valid/in_ready, sep_x/y/z, kinds, weight     to block
//   out      out_valid/out_ready, force_x/y/z, energy, clip  from block
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data        to block
//
// One beat is accepted every cycle while the output is not stalled.
// Each item passes stages 1-3, the 32-stage square root, stages 4-9 and the 49-stage divider.
// Reset clears all valid bits and the configuration registers; cfg_ready is always high.
// A stall on the output freezes the whole pipeline; in_ready follows it in the same cycle.
module harmonic_pair_force_unit import hpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] sep_x,
	input  logic signed [31:0] sep_y,
	input  logic signed [31:0] sep_z,
	input  logic               first_kind,
	input  logic               second_kind,
	input  logic [16:0]        energy_weight,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic signed [47:0] force_z,
	output logic [46:0]        pair_energy,
	output logic               clipped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	logic [31:0] k_aa_q, k_ab_q, k_bb_q, r0_aa_q, r0_ab_q, r0_bb_q;
	logic        en;

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_aa_q  <= '0;
			k_ab_q  <= '0;
			k_bb_q  <= '0;
			r0_aa_q <= '0;
			r0_ab_q <= '0;
			r0_bb_q <= '0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_K_AA:  k_aa_q  <= cfg_data;
				REG_K_AB:  k_ab_q  <= cfg_data;
				REG_K_BB:  k_bb_q  <= cfg_data;
				REG_R0_AA: r0_aa_q <= cfg_data;
				REG_R0_AB: r0_ab_q <= cfg_data;
				REG_R0_BB: r0_bb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: magnitudes, signs and kind pair.
	logic [LANES-1:0][31:0] sep_w;
	sq_side_t               side_w;
	logic                   vld_s1;
	sq_side_t               side_s1;

	assign sep_w = {sep_z, sep_y, sep_x};

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			side_w.neg[c] = sep_w[c][31];
			side_w.mag[c] = sep_w[c][31] ? 32'(-sep_w[c]) : sep_w[c];
		end
		if (first_kind != second_kind) begin
			side_w.pair = PAIR_AB;
		end else if (first_kind) begin
			side_w.pair = PAIR_BB;
		end else begin
			side_w.pair = PAIR_AA;
		end
		side_w.weight = energy_weight;
	end

	// Stage 2: squares. Stage 3: sum of squares.
	logic                   vld_s2, vld_s3;
	sq_side_t               side_s2, side_s3;
	logic [LANES-1:0][63:0] sq_s2;
	logic [63:0]            rsq_s3;

	// Stage 4: rest length difference. Stage 5: k times difference.
	logic        sq_vld;
	logic [31:0] root_w;
	sq_side_t    sq_side;
	logic [31:0] k_w, r0_w;
	logic        vld_s4, vld_s5;
	sq_side_t    side_s4, side_s5;
	logic [31:0] root_s4, root_s5, k_s4, drmag_s4, drmag_s5;
	logic        drneg_s4, drneg_s5;
	logic [63:0] kdr_s5;

	// Stage 6: partial products. Stage 7: dividends and e1.
	logic [47:0]            rk_w;
	logic                   vld_s6, vld_s7;
	logic [LANES-1:0][63:0] fl_s6;
	logic [LANES-1:0][47:0] fh_s6;
	logic [63:0]            el_s6;
	logic [47:0]            eh_s6;
	logic [LANES-1:0]       fneg_s6, live_s6, fneg_s7, live_s7;
	logic [31:0]            root_s6, root_s7;
	logic [16:0]            weight_s6, weight_s7;
	logic [LANES-1:0][79:0] fsum_w;
	logic [79:0]            esum_w;
	logic [LANES-1:0][NUM_W-1:0] num_s7;
	logic [63:0]            e1_s7;

	// Stage 8: weight partial products. Stage 9: energy and saturation.
	logic                        vld_s8, vld_s9;
	logic [48:0]                 ewl_s8, ewh_s8;
	logic [LANES-1:0][NUM_W-1:0] num_s8, num_s9;
	logic [LANES-1:0]            fneg_s8, live_s8;
	logic [31:0]                 root_s8;
	logic [80:0]                 prod_w;
	dv_side_t                    dv_side_w, dv_side_s9;

	logic                        dv_vld;
	logic [LANES-1:0][QUO_W-1:0] quo_w;
	dv_side_t                    dv_side;

	always_comb begin
		case (sq_side.pair)
			PAIR_AA: begin
				k_w  = k_aa_q;
				r0_w = r0_aa_q;
			end
			PAIR_BB: begin
				k_w  = k_bb_q;
				r0_w = r0_bb_q;
			end
			default: begin
				k_w  = k_ab_q;
				r0_w = r0_ab_q;
			end
		endcase
	end

	assign rk_w = kdr_s5[63:16];

	always_comb begin
		for (int c = 0; c < LANES; c++) begin
			fsum_w[c] = {fh_s6[c], 32'd0} + {16'd0, fl_s6[c]};
		end
		esum_w = {eh_s6, 32'd0} + {16'd0, el_s6};
	end

	always_comb begin
		prod_w               = {ewh_s8, 32'd0} + {32'd0, ewl_s8};
		dv_side_w.den        = root_s8;
		dv_side_w.fneg       = fneg_s8;
		dv_side_w.live       = live_s8;
		dv_side_w.eclip      = |prod_w[80:63];
		dv_side_w.energy     = dv_side_w.eclip ? ENERGY_MAX : prod_w[62:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_w;

			for (int c = 0; c < LANES; c++) begin
				sq_s2[c] <= {32'd0, side_s1.mag[c]} * {32'd0, side_s1.mag[c]};
			end
			side_s2 <= side_s1;

			rsq_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			side_s3 <= side_s2;

			side_s4  <= sq_side;
			root_s4  <= root_w;
			k_s4     <= k_w;
			drneg_s4 <= root_w < r0_w;
			drmag_s4 <= (root_w < r0_w) ? (r0_w - root_w) : (root_w - r0_w);

			kdr_s5   <= {32'd0, k_s4} * {32'd0, drmag_s4};
			drmag_s5 <= drmag_s4;
			drneg_s5 <= drneg_s4;
			root_s5  <= root_s4;
			side_s5  <= side_s4;

			for (int c = 0; c < LANES; c++) begin
				fl_s6[c]   <= {32'd0, rk_w[31:0]} * {32'd0, side_s5.mag[c]};
				fh_s6[c]   <= {32'd0, rk_w[47:32]} * {16'd0, side_s5.mag[c]};
				fneg_s6[c] <= drneg_s5 == side_s5.neg[c];
				live_s6[c] <= side_s5.mag[c] != 32'd0;
			end
			el_s6     <= {32'd0, rk_w[31:0]} * {32'd0, drmag_s5};
			eh_s6     <= {32'd0, rk_w[47:32]} * {16'd0, drmag_s5};
			root_s6   <= root_s5;
			weight_s6 <= side_s5.weight;

			for (int c = 0; c < LANES; c++) begin
				num_s7[c] <= {fsum_w[c], 1'b0};
			end
			e1_s7     <= esum_w[79:16];
			fneg_s7   <= fneg_s6;
			live_s7   <= live_s6;
			root_s7   <= root_s6;
			weight_s7 <= weight_s6;

			ewl_s8  <= {17'd0, e1_s7[31:0]} * {32'd0, weight_s7};
			ewh_s8  <= {17'd0, e1_s7[63:32]} * {32'd0, weight_s7};
			num_s8  <= num_s7;
			fneg_s8 <= fneg_s7;
			live_s8 <= live_s7;
			root_s8 <= root_s7;

			num_s9     <= num_s8;
			dv_side_s9 <= dv_side_w;
		end
	end

	hpf_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.rad      (rsq_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.root     (root_w),
		.out_side (sq_side)
	);

	hpf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.num      (num_s9),
		.in_side  (dv_side_s9),
		.out_vld  (dv_vld),
		.quo      (quo_w),
		.out_side (dv_side)
	);

	// Output register: force saturation and clip flag.
	logic [LANES-1:0][47:0] force_w;
	logic [LANES-1:0]       fclip_w;
	logic [48:0]            fmag;
	logic                   out_valid_q;
	logic [LANES-1:0][47:0] force_q;
	logic [46:0]            energy_q;
	logic                   clipped_q;

	always_comb begin
		fmag = '0;
		for (int c = 0; c < LANES; c++) begin
			fmag = dv_side.live[c] ? quo_w[c] : 49'd0;
			fclip_w[c] = 1'b0;
			if (dv_side.fneg[c]) begin
				if (fmag > FORCE_NEG_MAG) begin
					force_w[c] = FORCE_NEG_MIN;
					fclip_w[c] = 1'b1;
				end else begin
					force_w[c] = 48'(49'd0 - fmag);
				end
			end else begin
				if (fmag > FORCE_POS_MAG) begin
					force_w[c] = FORCE_POS_MAX;
					fclip_w[c] = 1'b1;
				end else begin
					force_w[c] = fmag[47:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			force_q   <= force_w;
			energy_q  <= dv_side.energy;
			clipped_q <= (|fclip_w) | dv_side.eclip;
		end
	end

	assign out_valid   = out_valid_q;
	assign force_x     = force_q[0];
	assign force_y     = force_q[1];
	assign force_z     = force_q[2];
	assign pair_energy = energy_q;
	assign clipped     = clipped_q;

	// A stalled pipeline must not move items between stages.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s9) && $stable(vld_s4) && $stable(vld_s1))
		else $error("pipeline valid moved during a stall");

endmodule

// ===== test/hpf_checker.sv =====
// Checker for the harmonic pair force unit: mirrors the configuration registers,
// predicts force and energy for every accepted pair and compares each output beat.
// Depends on hpf_pkg.
`timescale 1ns / 100ps

module hpf_checker import hpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] sep_x,
	input  logic signed [31:0] sep_y,
	input  logic signed [31:0] sep_z,
	input  logic               first_kind,
	input  logic               second_kind,
	input  logic [16:0]        energy_weight,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [47:0] force_x,
	input  logic signed [47:0] force_y,
	input  logic signed [47:0] force_z,
	input  logic [46:0]        pair_energy,
	input  logic               clipped,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 pending,
	output int                 fails
);

	typedef struct {
		logic [47:0] fx;
		logic [47:0] fy;
		logic [47:0] fz;
		logic [46:0] energy;
		logic        clip;
	} pair_force_t;

	logic [31:0] stiffness [3];
	logic [31:0] rest_len [3];
	pair_force_t expected_forces [$];

	function automatic pair_force_t harmonic_force(input logic [31:0] sx, input logic [31:0] sy,
			input logic [31:0] sz, input logic fk, input logic sk, input logic [16:0] w);
		logic [31:0]  comp [3];
		logic [32:0]  mag [3];
		logic         neg [3];
		logic [63:0]  rsq, rem, root, one, k, r0, drmag, rkmag;
		logic         dr_neg, fneg;
		logic [127:0] f, e1, en;
		logic [47:0]  fo [3];
		pair_t        pr;
		pair_force_t  res;
		comp[0] = sx;
		comp[1] = sy;
		comp[2] = sz;
		rsq = '0;
		res.clip = 1'b0;
		for (int c = 0; c < 3; c++) begin
			neg[c] = comp[c][31];
			mag[c] = neg[c] ? (33'h1_0000_0000 - {1'b0, comp[c]}) : {1'b0, comp[c]};
			rsq += 64'(mag[c]) * 64'(mag[c]);
		end
		rem = rsq;
		root = '0;
		one = 64'd1 << 62;
		while (one > rem)
			one >>= 2;
		while (one != 0) begin
			if (rem >= root + one) begin
				rem -= root + one;
				root = (root >> 1) + one;
			end else begin
				root >>= 1;
			end
			one >>= 2;
		end
		if (!fk && !sk)
			pr = PAIR_AA;
		else if (fk && sk)
			pr = PAIR_BB;
		else
			pr = PAIR_AB;
		k = 64'(stiffness[pr]);
		r0 = 64'(rest_len[pr]);
		dr_neg = root < r0;
		drmag = dr_neg ? (r0 - root) : (root - r0);
		rkmag = (k * drmag) >> 16;
		for (int c = 0; c < 3; c++) begin
			f = '0;
			if (root != 0 && rkmag != 0 && mag[c] != 0)
				f = (128'(rkmag) * 128'(2 * 64'(mag[c]))) / 128'(root);
			fneg = (dr_neg == neg[c]);
			if (fneg && f > 128'(FORCE_NEG_MAG)) begin
				f = 128'(FORCE_NEG_MAG);
				res.clip = 1'b1;
			end
			if (!fneg && f > 128'(FORCE_POS_MAG)) begin
				f = 128'(FORCE_POS_MAG);
				res.clip = 1'b1;
			end
			fo[c] = fneg ? (48'd0 - f[47:0]) : f[47:0];
		end
		e1 = (128'(rkmag) * 128'(drmag)) >> 16;
		en = (e1 * 128'(w)) >> 16;
		if (en > 128'(ENERGY_MAX)) begin
			en = 128'(ENERGY_MAX);
			res.clip = 1'b1;
		end
		res.fx = fo[0];
		res.fy = fo[1];
		res.fz = fo[2];
		res.energy = en[46:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_force_t exp_f;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				stiffness[i] = '0;
				rest_len[i] = '0;
			end
			expected_forces.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_K_AA:  stiffness[PAIR_AA] = cfg_data;
					REG_K_AB:  stiffness[PAIR_AB] = cfg_data;
					REG_K_BB:  stiffness[PAIR_BB] = cfg_data;
					REG_R0_AA: rest_len[PAIR_AA] = cfg_data;
					REG_R0_AB: rest_len[PAIR_AB] = cfg_data;
					REG_R0_BB: rest_len[PAIR_BB] = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_forces.size() == 0) begin
					$error("output beat with no pair outstanding");
					fails++;
				end else begin
					exp_f = expected_forces.pop_front();
					if (force_x !== exp_f.fx) begin
						$error("force_x: expected %h, got %h", exp_f.fx, force_x);
						fails++;
					end
					if (force_y !== exp_f.fy) begin
						$error("force_y: expected %h, got %h", exp_f.fy, force_y);
						fails++;
					end
					if (force_z !== exp_f.fz) begin
						$error("force_z: expected %h, got %h", exp_f.fz, force_z);
						fails++;
					end
					if (pair_energy !== exp_f.energy) begin
						$error("pair_energy: expected %h, got %h", exp_f.energy, pair_energy);
						fails++;
					end
					if (clipped !== exp_f.clip) begin
						$error("clipped: expected %b, got %b", exp_f.clip, clipped);
						fails++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_forces.push_back(harmonic_force(sep_x, sep_y, sep_z,
					first_kind, second_kind, energy_weight));
		end
		pending = expected_forces.size();
	end

endmodule

// ===== test/tb_harmonic_pair_force_unit.sv =====
// Testbench top for the harmonic pair force unit: drives configuration phases,
// directed and random pairs with bursty input and stalling output, and gives the verdict.
// Depends on hpf_pkg, harmonic_pair_force_unit and hpf_checker.
`timescale 1ns / 100ps

module tb_harmonic_pair_force_unit;
	import hpf_pkg::*;

	localparam int LATENCY = 91;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] sep_x, sep_y, sep_z;
	logic               first_kind, second_kind;
	logic [16:0]        energy_weight;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [47:0] force_x, force_y, force_z;
	logic [46:0]        pair_energy;
	logic               clipped;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	int                 pending;
	int                 fails;
	int                 cycles = 0;
	int                 burst_left;
	int                 stall_pct = 0;

	harmonic_pair_force_unit dut (.*);
	hpf_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("** harmonic_pair_force_unit: FAILED **");
			$finish;
		end
	end

	// Output stalls: the stall rate is redrawn periodically from the cycle counter and is sometimes zero.
	always @(posedge clk) begin
		if (cycles % 256 == 0)
			stall_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 80);
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic send_pair(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
			input logic fk, input logic sk, input logic [16:0] w);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		sep_x <= x;
		sep_y <= y;
		sep_z <= z;
		first_kind <= fk;
		second_kind <= sk;
		energy_weight <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that writes can follow back to back.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_pair_regs(input logic [31:0] kaa, input logic [31:0] kab,
			input logic [31:0] kbb, input logic [31:0] raa, input logic [31:0] rab,
			input logic [31:0] rbb);
		write_reg(REG_K_AA, kaa);
		write_reg(REG_K_AB, kab);
		write_reg(REG_K_BB, kbb);
		write_reg(REG_R0_AA, raa);
		write_reg(REG_R0_AB, rab);
		write_reg(REG_R0_BB, rbb);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_sep();
		case ($urandom_range(0, 5))
			0: return '0;
			1, 2: return $urandom;
			3: return 32'($urandom_range(0, 32'h0010_0000));
			4: return -32'($urandom_range(0, 32'h0010_0000));
			default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000);
		endcase
	endfunction

	task automatic random_pairs(input int count);
		for (int i = 0; i < count; i++)
			send_pair(rand_sep(), rand_sep(), rand_sep(), 1'($urandom), 1'($urandom),
				($urandom_range(0, 3) == 0) ? 17'($urandom_range(65536, 131071))
					: 17'($urandom_range(0, 65536)));
	endtask

	task automatic random_regs;
		set_pair_regs($urandom_range(0, 32'h0040_0000), $urandom, $urandom_range(0, 32'h0004_0000),
			$urandom_range(0, 32'h0080_0000), $urandom, $urandom_range(0, 32'h0002_0000));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		sep_x = '0;
		sep_y = '0;
		sep_z = '0;
		first_kind = 1'b0;
		second_kind = 1'b0;
		energy_weight = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs with mid-range coefficients.
		set_pair_regs(32'h0002_0000, 32'h0000_8000, 32'h0010_0000,
			32'h0001_0000, 32'h0003_0000, 32'h0000_4000);
		send_pair(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 17'd65536);
		send_pair(32'h0, 32'h0, 32'h0, 1'b1, 1'b1, 17'd131071);
		send_pair(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b1, 17'd65536);
		send_pair(32'h0, 32'hFFFF_0000, 32'h0, 1'b1, 1'b0, 17'd0);
		send_pair(32'h0, 32'h0, 32'h0003_0000, 1'b0, 1'b1, 17'd65536);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 17'd131071);
		send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 17'd65536);
		send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 17'd1);
		send_pair(32'h0000_0001, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 17'd32768);
		send_pair(32'h0000_4000, 32'h0, 32'h0, 1'b1, 1'b1, 17'd65536);
		drain();

		// Extreme coefficients: saturation of force and energy.
		set_pair_regs('1, '1, '1, '1, '1, 32'h0);
		send_pair(32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 17'd131071);
		send_pair(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1, 17'd131071);
		send_pair(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 17'd65536);
		send_pair(32'h0000_0001, 32'h0, 32'h0, 1'b0, 1'b1, 17'd65536);
		send_pair(32'hFFFF_FFFF, 32'h0000_0001, 32'h0, 1'b1, 1'b1, 17'd0);
		random_pairs(40);
		drain();

		// Writes to unused indexes must not change anything.
		write_reg(3'(REG_R0_BB) + 3'd1, $urandom);
		write_reg(3'(REG_R0_BB) + 3'd2, $urandom);
		set_pair_regs('0, '0, '0, '0, '0, '0);
		send_pair(32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0, 17'd65536);
		random_pairs(20);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			random_regs();
			random_pairs(80);
			drain();
		end

		set_pair_regs(32'h0001_0000, '1, $urandom, 32'h0, $urandom, '1);
		random_pairs(40);

		drain();
		if (fails == 0)
			$display("** harmonic_pair_force_unit: PASSED **");
		else
			$display("** harmonic_pair_force_unit: FAILED **");
		$finish;
	end

endmodule
